// ----- sv/vmpu_pkg.sv -----
// Shared types and constants for the velocity motion pose update block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package vmpu_pkg;

    localparam int ANGLE_BITS = 16;
    localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [30:0] TRIG_A = 31'd1686629713;
    localparam logic [30:0] TRIG_B = 31'd688904866;
    localparam logic [30:0] TRIG_C = 31'd76016977;
    localparam logic [31:0] RAD_TO_ANG = 32'd2734261102;

    localparam int NUM_W = 48;
    localparam int DEN_W = 26;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [15:0] STEP_TIME_RST = 16'd655;
    localparam logic [11:0] THRESH_RST = 12'd4;

    localparam logic REG_STEP_TIME = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_P, S_ANG, S_VD, S_TRIG, S_STX, S_STY, S_DIFF,
        S_NX, S_NY, S_DIVI, S_DIV, S_UPD, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPT, OP_P, OP_ANG, OP_VD, OP_TZ, OP_T2, OP_T3, OP_T4,
        OP_STX, OP_STY, OP_DIFF, OP_NX, OP_NY, OP_DIVI, OP_DIVS, OP_UPD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] tidx;
        logic       set_pose;
    } t_cmd;

    typedef struct packed {
        logic straight;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/vmpu_ctrl.sv -----
// Sequencing state machine for the pose update.
// Depends on vmpu_pkg; drives commands into vmpu_dp.
`default_nettype none
module vmpu_ctrl
    import vmpu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_action,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    t_state r_state, n_state;
    logic [1:0] r_tidx, n_tidx;
    logic [1:0] r_tstep, n_tstep;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic trig_last;

    assign trig_last = (r_tstep == 2'd3) && (i_stat.straight ? (r_tidx == 2'd1)
                                                               : (r_tidx == 2'd3));

    always_comb begin
        n_state = r_state;
        n_tidx = r_tidx;
        n_tstep = r_tstep;
        n_cnt = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_tidx = 2'd0;
                n_tstep = 2'd0;
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = i_action ? S_OUT : S_P;
                end
            end
            S_P:   n_state = S_ANG;
            S_ANG: n_state = i_stat.straight ? S_VD : S_TRIG;
            S_VD:  n_state = S_TRIG;
            S_TRIG: begin
                n_tstep = r_tstep + 2'd1;
                if (r_tstep == 2'd3) begin
                    n_tidx = r_tidx + 2'd1;
                end
                if (trig_last) begin
                    n_state = i_stat.straight ? S_STX : S_DIFF;
                end
            end
            S_STX:  n_state = S_STY;
            S_STY:  n_state = S_UPD;
            S_DIFF: n_state = S_NX;
            S_NX:   n_state = S_NY;
            S_NY:   n_state = S_DIVI;
            S_DIVI: n_state = S_DIV;
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        o_cmd.tidx = r_tidx;
        o_cmd.set_pose = i_action;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPT;
                end
            end
            S_P:   o_cmd.op = OP_P;
            S_ANG: o_cmd.op = OP_ANG;
            S_VD:  o_cmd.op = OP_VD;
            S_TRIG: begin
                unique case (r_tstep)
                    2'd0: o_cmd.op = OP_TZ;
                    2'd1: o_cmd.op = OP_T2;
                    2'd2: o_cmd.op = OP_T3;
                    default: o_cmd.op = OP_T4;
                endcase
            end
            S_STX:  o_cmd.op = OP_STX;
            S_STY:  o_cmd.op = OP_STY;
            S_DIFF: o_cmd.op = OP_DIFF;
            S_NX:   o_cmd.op = OP_NX;
            S_NY:   o_cmd.op = OP_NY;
            S_DIVI: o_cmd.op = OP_DIVI;
            S_DIV:  o_cmd.op = OP_DIVS;
            S_UPD:  o_cmd.op = OP_UPD;
            S_OUT:  o_out_valid = 1'b1;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tidx <= 2'd0;
            r_tstep <= 2'd0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_tidx <= n_tidx;
            r_tstep <= n_tstep;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- sv/vmpu_dp.sv -----
// Datapath: pose registers, shared multiplier, sine polynomial and two divider lanes.
// Depends on vmpu_pkg; commanded by vmpu_ctrl.
`default_nettype none
module vmpu_dp
    import vmpu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic        [15:0] i_step_time,
    input  wire logic        [11:0] i_thresh,
    input  wire logic signed [15:0] i_lin_speed,
    input  wire logic signed [15:0] i_ang_speed,
    input  wire logic signed [31:0] i_new_x,
    input  wire logic signed [31:0] i_new_y,
    input  wire logic        [15:0] i_new_heading,
    output t_stat                   o_stat,
    output logic signed [31:0]      o_pose_x,
    output logic signed [31:0]      o_pose_y,
    output logic        [15:0]      o_pose_heading
);

    logic signed [31:0] r_pos_x, r_pos_y;
    logic [15:0] r_heading;
    logic signed [15:0] r_v, r_w;
    logic signed [32:0] r_p, r_vd;
    logic [31:0] r_h2;
    logic r_straight;
    logic [30:0] r_z, r_z2, r_t;
    logic r_neg;
    logic signed [31:0] r_trig [4];
    logic signed [32:0] r_dsx, r_dsy;
    logic signed [29:0] r_sdx, r_sdy;
    logic [NUM_W-1:0] r_nx, r_ny;
    logic r_sgx, r_sgy;
    logic [DEN_W-1:0] r_den, r_remx, r_remy;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic [31:0] ang, ang_m;
    logic [30:0] zval;
    logic [16:0] wabs;
    logic [DEN_W:0] trx, try_;
    logic signed [49:0] dx, dy, sx, sy;
    logic [67:0] pabs;
    logic [30:0] pmid;

    assign wabs = r_w[15] ? 17'(-$signed({r_w[15], r_w})) : {1'b0, r_w};

    always_comb begin
        unique case (i_cmd.tidx)
            2'd0: ang = {r_heading, 16'd0};
            2'd1: ang = {r_heading, 16'd0} + QUARTER;
            2'd2: ang = r_h2;
            default: ang = r_h2 + QUARTER;
        endcase
        ang_m = ang & ANG_MASK;
        zval = ang_m[30] ? (31'(QUARTER) - {1'b0, ang_m[29:0]}) : {1'b0, ang_m[29:0]};
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_P:   begin mul_a = 34'(r_w);  mul_b = {18'd0, i_step_time}; end
            OP_ANG: begin mul_a = 34'(r_p);  mul_b = {2'd0, RAD_TO_ANG}; end
            OP_VD:  begin mul_a = 34'(r_v);  mul_b = {18'd0, i_step_time}; end
            OP_TZ:  begin mul_a = {3'd0, zval}; mul_b = {3'd0, zval}; end
            OP_T2:  begin mul_a = {3'd0, TRIG_C}; mul_b = {3'd0, r_z2}; end
            OP_T3:  begin mul_a = {3'd0, r_t}; mul_b = {3'd0, r_z2}; end
            OP_T4:  begin mul_a = {3'd0, r_t}; mul_b = {3'd0, r_z}; end
            OP_STX: begin mul_a = 34'(r_vd); mul_b = 34'(r_trig[1]); end
            OP_STY: begin mul_a = 34'(r_vd); mul_b = 34'(r_trig[0]); end
            OP_NX:  begin mul_a = 34'(r_v);  mul_b = 34'(r_dsx); end
            OP_NY:  begin mul_a = 34'(r_v);  mul_b = 34'(r_dsy); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign pabs = prod[67] ? 68'(-prod) : 68'(prod);
    assign pmid = prod[60:30];

    assign trx = {r_remx, r_nx[NUM_W-1]};
    assign try_ = {r_remy, r_ny[NUM_W-1]};

    always_comb begin
        if (r_straight) begin
            dx = 50'(r_sdx);
            dy = 50'(r_sdy);
        end else begin
            dx = (r_sgx ^ r_w[15]) ? -$signed({2'b0, r_nx}) : $signed({2'b0, r_nx});
            dy = (r_sgy ^ r_w[15]) ? -$signed({2'b0, r_ny}) : $signed({2'b0, r_ny});
        end
        sx = 50'(r_pos_x) + dx;
        sy = 50'(r_pos_y) + dy;
    end

    function automatic logic signed [31:0] sat32(input logic signed [49:0] s);
        if (s > 50'sd2147483647) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (s < -50'sd2147483648) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = s[31:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_heading <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_CAPT: begin
                    if (i_cmd.set_pose) begin
                        r_pos_x <= i_new_x;
                        r_pos_y <= i_new_y;
                        r_heading <= i_new_heading;
                    end
                end
                OP_UPD: begin
                    r_pos_x <= sat32(sx);
                    r_pos_y <= sat32(sy);
                    r_heading <= r_h2[31:16];
                end
                default: begin
                    r_heading <= r_heading;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPT: begin
                r_v <= i_lin_speed;
                r_w <= i_ang_speed;
            end
            OP_P: begin
                r_p <= prod[32:0];
                r_straight <= (r_w == 16'sd0) || (wabs < {5'd0, i_thresh});
            end
            OP_ANG: r_h2 <= {r_heading, 16'd0} + prod[61:30];
            OP_VD:  r_vd <= prod[32:0];
            OP_TZ: begin
                r_z <= zval;
                r_neg <= ang_m[31];
                r_z2 <= pmid;
            end
            OP_T2: r_t <= TRIG_B - pmid;
            OP_T3: r_t <= TRIG_A - pmid;
            OP_T4: r_trig[i_cmd.tidx] <= r_neg ? -$signed({1'b0, pmid}) : $signed({1'b0, pmid});
            OP_STX: r_sdx <= prod[67:38];
            OP_STY: r_sdy <= prod[67:38];
            OP_DIFF: begin
                r_dsx <= 33'(r_trig[2]) - 33'(r_trig[0]);
                r_dsy <= 33'(r_trig[1]) - 33'(r_trig[3]);
            end
            OP_NX: begin
                r_nx <= pabs[NUM_W-1:0];
                r_sgx <= prod[67];
            end
            OP_NY: begin
                r_ny <= pabs[NUM_W-1:0];
                r_sgy <= prod[67];
            end
            OP_DIVI: begin
                r_den <= {wabs[15:0], 10'd0};
                r_remx <= '0;
                r_remy <= '0;
            end
            OP_DIVS: begin
                if (trx >= {1'b0, r_den}) begin
                    r_remx <= DEN_W'(trx - {1'b0, r_den});
                    r_nx <= {r_nx[NUM_W-2:0], 1'b1};
                end else begin
                    r_remx <= trx[DEN_W-1:0];
                    r_nx <= {r_nx[NUM_W-2:0], 1'b0};
                end
                if (try_ >= {1'b0, r_den}) begin
                    r_remy <= DEN_W'(try_ - {1'b0, r_den});
                    r_ny <= {r_ny[NUM_W-2:0], 1'b1};
                end else begin
                    r_remy <= try_[DEN_W-1:0];
                    r_ny <= {r_ny[NUM_W-2:0], 1'b0};
                end
            end
            default: begin
                r_v <= r_v;
            end
        endcase
    end

    assign o_stat.straight = r_straight;
    assign o_pose_x = r_pos_x;
    assign o_pose_y = r_pos_y;
    assign o_pose_heading = r_heading;

endmodule
`default_nettype wire

// ----- sv/velocity_motion_pose_update_top.sv -----
// Top level of the velocity motion pose update: register port, controller and datapath.
// Depends on vmpu_pkg, vmpu_ctrl and vmpu_dp.
//
//   channel   direction  handshake               payload
//   s_*       in         s_tvalid / s_tready     move or set-pose item
//   m_*       out        m_tvalid / m_tready     pose after the item
//   APB       in         psel, penable, pready   step_time, straight_threshold
//
// A set-pose item offers its result in the cycle after acceptance. For a straight move the
// wait is set by the shared multiplier running two sine evaluations of four products each.
// For an arc move it is set by four sine evaluations and the bit-per-cycle divider
// (48 steps). Reset is synchronous and needs no clearing pass. One item is in work at a
// time; the input is held off until the result transfer completes, and the next item is
// taken in the cycle after that transfer.
`default_nettype none
module velocity_motion_pose_update_top
    import vmpu_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] lin_speed, [31:16] ang_speed, [63:32] new_x, [95:64] new_y,
    // [111:96] new_heading
    input  wire logic [111:0] s_tdata,
    // [0] action
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] pose_x, [63:32] pose_y, [79:64] pose_heading
    output logic [79:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] r_step_time;
    logic [11:0] r_thresh;
    t_cmd cmd;
    t_stat stat;
    logic signed [31:0] pose_x, pose_y;
    logic [15:0] pose_heading;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RST;
            r_thresh <= THRESH_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_STEP_TIME: r_step_time <= pwdata[15:0];
                default:       r_thresh <= pwdata[11:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STEP_TIME: prdata = {16'd0, r_step_time};
            default:       prdata = {20'd0, r_thresh};
        endcase
    end

    vmpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_action    (s_tuser[0]),
        .i_out_ready (m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid)
    );

    vmpu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_step_time    (r_step_time),
        .i_thresh       (r_thresh),
        .i_lin_speed    (s_tdata[15:0]),
        .i_ang_speed    (s_tdata[31:16]),
        .i_new_x        (s_tdata[63:32]),
        .i_new_y        (s_tdata[95:64]),
        .i_new_heading  (s_tdata[111:96]),
        .o_stat         (stat),
        .o_pose_x       (pose_x),
        .o_pose_y       (pose_y),
        .o_pose_heading (pose_heading)
    );

    assign m_tdata = {pose_heading, pose_y, pose_x};

endmodule
`default_nettype wire

// ----- tb/velocity_motion_pose_update_top_tb.sv -----
// Testbench for the velocity motion pose update block: directed and random items
// checked against a fixed-point pose predictor. Depends on vmpu_pkg and the top level.
`default_nettype none
module velocity_motion_pose_update_top_tb;
    import vmpu_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] hd;
    } t_pose;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    velocity_motion_pose_update_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam logic [63:0] TURN_GAIN = 64'd2734261102;
    localparam int LIMIT_CYCLES = 1_000_000;

    logic [15:0] step_time;
    logic [11:0] thresh;
    t_pose       pose;
    t_pose       pose_q[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    longint      cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint floor_shr(longint a, int s);
        return a >>> s;
    endfunction

    function automatic longint sine_q30(logic [31:0] ang);
        logic [31:0] a;
        logic [63:0] f, z, z2, t;
        a = ang & ANG_MASK;
        f = {34'd0, a[29:0]};
        z = a[30] ? (64'h4000_0000 - f) : f;
        z2 = (z * z) >> 30;
        t = (64'(TRIG_C) * z2) >> 30;
        t = 64'(TRIG_B) - t;
        t = (t * z2) >> 30;
        t = 64'(TRIG_A) - t;
        t = (t * z) >> 30;
        return a[31] ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void advance_pose(logic act, logic [111:0] d);
        longint v, w, wabs, p, dd, dx, dy, vd, den;
        logic [31:0] h, h2;
        if (act) begin
            pose.x = d[63:32];
            pose.y = d[95:64];
            pose.hd = d[111:96];
        end else begin
            v = longint'($signed(d[15:0]));
            w = longint'($signed(d[31:16]));
            wabs = (w < 0) ? -w : w;
            h = {pose.hd, 16'd0};
            p = w * longint'(step_time);
            dd = floor_shr(p * longint'(TURN_GAIN), 30);
            h2 = h + dd[31:0];
            if (w == 0 || wabs < longint'(thresh)) begin
                vd = v * longint'(step_time);
                dx = floor_shr(vd * sine_q30(h + QUARTER), 38);
                dy = floor_shr(vd * sine_q30(h), 38);
            end else begin
                den = w * 1024;
                dx = (v * (sine_q30(h2) - sine_q30(h))) / den;
                dy = (v * (sine_q30(h + QUARTER) - sine_q30(h2 + QUARTER))) / den;
            end
            pose.x = 32'(sat32(longint'($signed(pose.x)) + dx));
            pose.y = 32'(sat32(longint'($signed(pose.y)) + dy));
            pose.hd = h2[31:16];
        end
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("velocity_motion_pose_update_top_tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                t_pose e;
                e = pose_q.pop_front();
                if (m_tdata[31:0] !== e.x)
                    $display("%0t: pose_x exp %h got %h", $time, e.x, m_tdata[31:0]);
                if (m_tdata[63:32] !== e.y)
                    $display("%0t: pose_y exp %h got %h", $time, e.y, m_tdata[63:32]);
                if (m_tdata[79:64] !== e.hd)
                    $display("%0t: heading exp %h got %h", $time, e.hd, m_tdata[79:64]);
                if (m_tdata !== {e.hd, e.y, e.x}) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr[2] == 1'b0) step_time = data[15:0];
        else thresh = data[11:0];
        @(posedge i_clk);
    endtask

    task automatic send_item(logic act, logic [111:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1; s_tdata <= d; s_tuser <= act;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        advance_pose(act, d);
        pose_q.push_back(pose);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_move(logic [15:0] v, logic [15:0] w);
        send_item(1'b0, 112'({$urandom, $urandom, $urandom, w, v}));
    endtask

    task automatic send_set(logic [31:0] x, logic [31:0] y, logic [15:0] hd);
        send_item(1'b1, {hd, y, x, 16'($urandom), 16'($urandom)});
    endtask

    task automatic random_item();
        int k;
        k = $urandom_range(99);
        if (k < 8)
            send_set($urandom, $urandom, 16'($urandom));
        else if (k < 14)
            send_set($urandom_range(2000) << 16, $urandom_range(2000) << 16, 16'($urandom));
        else if (k < 40)
            send_move(16'($urandom), 16'($urandom_range(2 * thresh + 2) - thresh - 1));
        else
            send_move(16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        send_move(16'h0100, 16'h0000);
        send_move(16'h7FFF, 16'h0000);
        send_move(16'h8000, 16'h0000);
        send_move(16'h0100, 16'h1000);
        send_move(16'h0100, 16'hF000);
        send_move(16'h7FFF, 16'h0004);
        send_move(16'h7FFF, 16'h0003);
        send_move(16'h8000, 16'hFFFC);
        send_move(16'h7FFF, 16'h7FFF);
        send_move(16'h8000, 16'h8000);
        send_set(32'h7FFF_0000, 32'h7FFF_0000, 16'h4000);
        send_move(16'h7FFF, 16'h0000);
        send_move(16'h7FFF, 16'h0005);
        send_set(32'h8000_0000, 32'h8000_0000, 16'hC000);
        send_move(16'h7FFF, 16'h0000);
        send_move(16'h8000, 16'h0010);
        send_set(32'h0, 32'h0, 16'hFFFF);
        send_set(32'hFFFF_FFFF, 32'h1234_5678, 16'h8000);
        send_move(16'h0000, 16'h2000);
        drain();
    endtask

    task automatic test_thresholds();
        reg_write(3'd4, 32'hFFFF_F000);
        send_move(16'h0200, 16'h0000);
        send_move(16'h0200, 16'h0001);
        drain();
        reg_write(3'd4, 32'hFFFF_FFFF);
        reg_write(3'd0, 32'hFFFF_FFFF);
        repeat (40) send_move(16'($urandom), 16'($urandom_range(8000) - 4000));
        send_move(16'h0300, 16'h0FFF);
        drain();
        reg_write(3'd0, 32'h0);
        repeat (10) random_item();
        drain();
        reg_write(3'd4, 32'd64);
        reg_write(3'd0, 32'd6553);
        repeat (10) random_item();
        drain();
        reg_write(3'd6, 32'h5);
        reg_write(3'd0, 32'd655);
        reg_write(3'd4, 32'd4);
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) random_item();
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles <= 600;
        repeat (8) random_item();
        drain();
        send_set(32'h0001_0000, 32'h0002_0000, 16'h2000);
        drain();
        send_move(16'h0100, 16'h0800);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_tready = 1'b0;
        cycles = 0; errors = 0; hold_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        step_time = STEP_TIME_RST; thresh = THRESH_RST;
        pose = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_thresholds();
        test_random(340, 0, 0);
        test_random(340, 75, 0);
        test_random(340, 0, 75);
        test_random(340, 25, 25);
        test_backpressure();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("velocity_motion_pose_update_top_tb: clean");
        end else begin
            $display("velocity_motion_pose_update_top_tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/vmpu_pkg.sv
sv/vmpu_ctrl.sv
sv/vmpu_dp.sv
sv/velocity_motion_pose_update_top.sv
tb/velocity_motion_pose_update_top_tb.sv
